// File: hdl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// Needs nothing else; each macro clocks and resets the property itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pdc_pkg.sv
// Constants, types and the month table of the packed date converter.
// No dependencies; used by the converter and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

  // Calendar arithmetic.
  localparam logic [63:0] DAYS_PER_ERA     = 64'd146097;
  localparam logic [63:0] DAYS_JAN_TO_MAR  = 64'd60;   // 1 Jan year 0 to 1 Mar year 0
  // Eras added so that the shifted day count is never negative.
  localparam logic [63:0] ERA_BIAS         = 64'd14700;
  localparam logic [33:0] Z_BIAS           = 34'(ERA_BIAS * DAYS_PER_ERA - DAYS_JAN_TO_MAR);
  localparam logic [63:0] DAYS_PER_4Y      = 64'd1460;
  localparam logic [63:0] DAYS_PER_CENT    = 64'd36524;
  localparam logic [63:0] DAYS_PER_YEAR    = 64'd365;
  localparam logic [63:0] YEARS_PER_ERA    = 64'd400;
  localparam logic [63:0] DAYS_PER_5MONTHS = 64'd153;

  localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
  localparam logic [63:0] SECONDS_PER_HOUR = 64'd3600;
  localparam logic [63:0] SECONDS_PER_MIN  = 64'd60;

  // Reciprocals. The era one is a floor estimate that may come out one low;
  // the others are rounded up with enough shift to be exact over their input range.
  localparam int          ERA_SHIFT  = 33;
  localparam logic [15:0] ERA_RECIP  = 16'((64'd1 << ERA_SHIFT) / DAYS_PER_ERA);
  localparam int          D4Y_SHIFT  = 29;
  localparam logic [18:0] D4Y_RECIP  =
    19'(((64'd1 << D4Y_SHIFT) + DAYS_PER_4Y - 64'd1) / DAYS_PER_4Y);
  localparam int          YR_SHIFT   = 27;
  localparam logic [18:0] YR_RECIP   =
    19'(((64'd1 << YR_SHIFT) + DAYS_PER_YEAR - 64'd1) / DAYS_PER_YEAR);
  localparam int          M5_SHIFT   = 19;
  localparam logic [11:0] M5_RECIP   =
    12'(((64'd1 << M5_SHIFT) + DAYS_PER_5MONTHS - 64'd1) / DAYS_PER_5MONTHS);
  localparam int          HR_SHIFT   = 29;
  localparam logic [17:0] HR_RECIP   =
    18'(((64'd1 << HR_SHIFT) + SECONDS_PER_HOUR - 64'd1) / SECONDS_PER_HOUR);
  localparam int          MIN_SHIFT  = 18;
  localparam logic [12:0] MIN_RECIP  =
    13'(((64'd1 << MIN_SHIFT) + SECONDS_PER_MIN - 64'd1) / SECONDS_PER_MIN);

  // Legal result ranges.
  localparam logic [3:0] MONTH_MIN   = 4'd1;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [4:0] DAY_MIN     = 5'd1;
  localparam logic [4:0] DAY_MAX     = 5'd31;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam logic [5:0] SECOND_MAX  = 6'd59;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } tm_t;

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    unique case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

`default_nettype wire

// File: hdl/packed_date_to_calendar.sv
// Packed timestamp to calendar date and time of day, nine-stage pipeline.
// Depends on pdc_pkg for constants, the time struct and the month table.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packed timestamp per cycle while in_stall_o is low (signed day
// count since 1 January of year 0, plus a 32-bit fraction of a day) and
// returns the proleptic Gregorian year, month and day together with hours,
// minutes and truncated seconds. Each request passes through the pipeline
// stages in order, one stage per constant multiply or compare-and-subtract.
// Each stage holds its data while the stage after it is full and stalled, so
// empty stages still fill behind a stalled result and nothing is lost.
module packed_date_to_calendar (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] day_count_i,
  input  wire logic        [31:0] day_fraction_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      year_o,
  output logic        [3:0]       month_o,
  output logic        [4:0]       day_of_month_o,
  output logic        [4:0]       hours_o,
  output logic        [5:0]       minutes_o,
  output logic        [5:0]       seconds_o
);

  localparam int NumStages = 9;

  // Stage handshake.
  logic [NumStages:1] v_q;
  logic [NumStages:1] rdy;
  logic [NumStages-1:0] v_in;

  always_comb begin
    rdy[NumStages] = !v_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in       = {v_q[NumStages-1:1], in_valid_i};
  assign in_stall_o = !rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k-1];
        end
      end
    end
  end

  // Stage 1: shift to days since 1 March, biased positive; seconds of the day.
  logic [33:0] zsum;
  logic [48:0] sprod;
  logic [32:0] zb1_q;
  logic [16:0] secs1_q;

  assign zsum  = {{2{day_count_i[31]}}, day_count_i} + pdc_pkg::Z_BIAS;
  assign sprod = 49'(day_fraction_i) * 49'(pdc_pkg::SECONDS_PER_DAY);

  // Stage 2: era estimate; hours.
  logic [48:0] eprod;
  logic [34:0] hprod;
  logic [32:0] zb2_q;
  logic [14:0] q2_q;
  logic [16:0] secs2_q;
  logic [4:0]  hrs2_q;

  assign eprod = 49'(zb1_q) * 49'(pdc_pkg::ERA_RECIP);
  assign hprod = 35'(secs1_q) * 35'(pdc_pkg::HR_RECIP);

  // Stage 3: remainder against the era estimate; seconds within the hour.
  logic [32:0] qd;
  logic [32:0] rdiff;
  logic [16:0] hsecs;
  logic [16:0] hrem;
  logic [18:0] r3_q;
  logic [14:0] q3_q;
  logic [4:0]  hrs3_q;
  logic [11:0] rem3_q;

  assign qd    = 33'(q2_q) * 33'(pdc_pkg::DAYS_PER_ERA);
  assign rdiff = zb2_q - qd;
  assign hsecs = 17'(hrs2_q) * 17'(pdc_pkg::SECONDS_PER_HOUR);
  assign hrem  = secs2_q - hsecs;

  // Stage 4: correct the era; minutes.
  logic        r_over;
  logic [18:0] r_fix;
  logic [14:0] q_fix;
  logic [24:0] mprod;
  logic [17:0] doe4_q;
  logic [15:0] era4_q;
  logic [4:0]  hrs4_q;
  logic [11:0] rem4_q;
  logic [5:0]  min4_q;

  assign r_over = r3_q >= 19'(pdc_pkg::DAYS_PER_ERA);
  assign r_fix  = r_over ? r3_q - 19'(pdc_pkg::DAYS_PER_ERA) : r3_q;
  assign q_fix  = r_over ? q3_q + 15'd1 : q3_q;
  assign mprod  = 25'(rem3_q) * 25'(pdc_pkg::MIN_RECIP);

  // Stage 5: leap-corrected day of era; seconds.
  logic [36:0] d4prod;
  logic [2:0]  cent_cnt;
  logic        last_day;
  logic [11:0] msecs;
  logic [11:0] srem;
  logic [17:0] n5_q;
  logic [17:0] doe5_q;
  logic [15:0] era5_q;
  pdc_pkg::tm_t tm5_q;

  assign d4prod   = 37'(doe4_q) * 37'(pdc_pkg::D4Y_RECIP);
  // Whole centuries in the era, found by compare since there are at most four.
  assign cent_cnt = 3'(doe4_q >= 18'(pdc_pkg::DAYS_PER_CENT))
                  + 3'(doe4_q >= 18'(pdc_pkg::DAYS_PER_CENT * 64'd2))
                  + 3'(doe4_q >= 18'(pdc_pkg::DAYS_PER_CENT * 64'd3))
                  + 3'(doe4_q >= 18'(pdc_pkg::DAYS_PER_CENT * 64'd4));
  assign last_day = doe4_q == 18'(pdc_pkg::DAYS_PER_ERA - 64'd1);
  assign msecs    = 12'(min4_q) * 12'(pdc_pkg::SECONDS_PER_MIN);
  assign srem     = rem4_q - msecs;

  // Stage 6: year of era; first year of the era.
  logic [36:0] yprod;
  logic [8:0]  yoe6_q;
  logic [23:0] y4006_q;
  logic [17:0] doe6_q;
  pdc_pkg::tm_t tm6_q;

  assign yprod = 37'(n5_q) * 37'(pdc_pkg::YR_RECIP);

  // Stage 7: day of the March-based year; year.
  logic [1:0]  yc_cnt;
  logic [17:0] ydays;
  logic [17:0] doy_full;
  logic [8:0]  doy7_q;
  logic [23:0] y7_q;
  pdc_pkg::tm_t tm7_q;

  assign yc_cnt   = 2'(yoe6_q >= 9'd100) + 2'(yoe6_q >= 9'd200) + 2'(yoe6_q >= 9'd300);
  assign ydays    = 18'(yoe6_q) * 18'(pdc_pkg::DAYS_PER_YEAR)
                  + 18'(yoe6_q[8:2]) - 18'(yc_cnt);
  assign doy_full = doe6_q - ydays;

  // Stage 8: March-based month.
  logic [10:0] mp_num;
  logic [22:0] mpprod;
  logic [3:0]  mp8_q;
  logic [8:0]  doy8_q;
  logic [23:0] y8_q;
  pdc_pkg::tm_t tm8_q;

  assign mp_num = ({2'b00, doy7_q} << 2) + 11'(doy7_q) + 11'd2;
  assign mpprod = 23'(mp_num) * 23'(pdc_pkg::M5_RECIP);

  // Stage 9: output register.
  logic [8:0]  dom_full;
  logic [3:0]  month_d;
  logic [23:0] year_d;
  logic [23:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  dom_q;
  pdc_pkg::tm_t tm9_q;

  assign dom_full = doy8_q - pdc_pkg::month_start(mp8_q) + 9'd1;
  // January and February belong to the next calendar year.
  assign month_d  = (mp8_q < 4'd10) ? mp8_q + 4'd3 : mp8_q - 4'd9;
  assign year_d   = (month_d <= 4'd2) ? y8_q + 24'd1 : y8_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      zb1_q   <= zsum[32:0];
      secs1_q <= sprod[48:32];
    end
    if (rdy[2]) begin
      zb2_q   <= zb1_q;
      q2_q    <= eprod[47:33];
      secs2_q <= secs1_q;
      hrs2_q  <= hprod[33:29];
    end
    if (rdy[3]) begin
      r3_q   <= rdiff[18:0];
      q3_q   <= q2_q;
      hrs3_q <= hrs2_q;
      rem3_q <= hrem[11:0];
    end
    if (rdy[4]) begin
      doe4_q <= r_fix[17:0];
      era4_q <= 16'(q_fix) - 16'(pdc_pkg::ERA_BIAS);
      hrs4_q <= hrs3_q;
      rem4_q <= rem3_q;
      min4_q <= mprod[23:18];
    end
    if (rdy[5]) begin
      n5_q          <= doe4_q - 18'(d4prod[35:29]) + 18'(cent_cnt) - 18'(last_day);
      doe5_q        <= doe4_q;
      era5_q        <= era4_q;
      tm5_q.hours   <= hrs4_q;
      tm5_q.minutes <= min4_q;
      tm5_q.seconds <= srem[5:0];
    end
    if (rdy[6]) begin
      yoe6_q  <= yprod[35:27];
      y4006_q <= {{8{era5_q[15]}}, era5_q} * 24'(pdc_pkg::YEARS_PER_ERA);
      doe6_q  <= doe5_q;
      tm6_q   <= tm5_q;
    end
    if (rdy[7]) begin
      doy7_q <= doy_full[8:0];
      y7_q   <= y4006_q + 24'(yoe6_q);
      tm7_q  <= tm6_q;
    end
    if (rdy[8]) begin
      mp8_q  <= mpprod[22:19];
      doy8_q <= doy7_q;
      y8_q   <= y7_q;
      tm8_q  <= tm7_q;
    end
    if (rdy[9]) begin
      year_q  <= year_d;
      month_q <= month_d;
      dom_q   <= dom_full[4:0];
      tm9_q   <= tm8_q;
    end
  end

  assign out_valid_o    = v_q[NumStages];
  assign year_o         = $signed(year_q);
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign hours_o        = tm9_q.hours;
  assign minutes_o      = tm9_q.minutes;
  assign seconds_o      = tm9_q.seconds;

endmodule

`default_nettype wire

// File: hdl/pdc_checker.sv
// Port-level checker for the packed date converter, bound to the top level.
// Depends on pdc_pkg for result ranges and on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pdc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [23:0] year_o,
  input wire logic        [3:0]  month_o,
  input wire logic        [4:0]  day_of_month_o,
  input wire logic        [4:0]  hours_o,
  input wire logic        [5:0]  minutes_o,
  input wire logic        [5:0]  seconds_o
);

  // A stalled result keeps its valid and its whole payload.
  `PDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(year_o) && $stable(month_o) && $stable(day_of_month_o)
    && $stable(hours_o) && $stable(minutes_o) && $stable(seconds_o),
    "stalled result changed")

  `PDC_ASSERT_IMPLY(a_date_range, clk_i, rst_ni, out_valid_o,
    month_o >= pdc_pkg::MONTH_MIN && month_o <= pdc_pkg::MONTH_MAX
    && day_of_month_o >= pdc_pkg::DAY_MIN && day_of_month_o <= pdc_pkg::DAY_MAX,
    "date field out of range")

  `PDC_ASSERT_IMPLY(a_time_range, clk_i, rst_ni, out_valid_o,
    hours_o <= pdc_pkg::HOUR_MAX && minutes_o <= pdc_pkg::MINUTE_MAX
    && seconds_o <= pdc_pkg::SECOND_MAX,
    "time field out of range")

  // With the output register empty, every stage can move, so input is never stalled.
  `PDC_ASSERT_IMPLY(a_empty_takes, clk_i, rst_ni, !out_valid_o, !in_stall_o,
    "input stalled with empty output")

endmodule

bind packed_date_to_calendar pdc_checker u_pdc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .year_o         (year_o),
  .month_o        (month_o),
  .day_of_month_o (day_of_month_o),
  .hours_o        (hours_o),
  .minutes_o      (minutes_o),
  .seconds_o      (seconds_o)
);

`default_nettype wire
